// File: rtl/pgtp_pkg.sv
// ----------------------------------------------------------------------------
// pgtp_pkg
// Shared types, constants and the arctangent table for the go-to-point
// drive controller.
// ----------------------------------------------------------------------------
package pgtp_pkg;

    localparam int ACC_W      = 62;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 26;
    localparam int ROOT_W     = 51;
    localparam int CRD_W      = 44;
    localparam int ANG_W      = 25;
    localparam int ATAN_IDX_W = 5;

    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Y = 3'd1;
    localparam logic [2:0] REG_KP_TURN  = 3'd2;
    localparam logic [2:0] REG_KI_TURN  = 3'd3;
    localparam logic [2:0] REG_KD_TURN  = 3'd4;
    localparam logic [2:0] REG_KP_DRIVE = 3'd5;
    localparam logic [2:0] REG_KI_DRIVE = 3'd6;
    localparam logic [2:0] REG_KD_DRIVE = 3'd7;

    localparam logic signed [ANG_W-1:0] DEG180_FINE = 25'sd5898240;
    localparam logic signed [18:0] FULL_TURN = 19'sd46080;
    localparam logic signed [18:0] NEG_HALF_TURN = -19'sd23040;
    localparam logic [49:0] TOL_SQ = 50'd65536;
    localparam logic signed [51:0] DRIVE_MIN = 52'sd640;
    localparam logic signed [51:0] DRIVE_MAX = 52'sd3840;

    typedef struct packed {
        logic clr;
        logic issue;
    } t_mac_ctl;

    function automatic logic signed [ANG_W-1:0] atan_fine(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 25'sd1474560;
            5'd1:  v = 25'sd870484;
            5'd2:  v = 25'sd459940;
            5'd3:  v = 25'sd233473;
            5'd4:  v = 25'sd117189;
            5'd5:  v = 25'sd58652;
            5'd6:  v = 25'sd29333;
            5'd7:  v = 25'sd14667;
            5'd8:  v = 25'sd7334;
            5'd9:  v = 25'sd3667;
            5'd10: v = 25'sd1833;
            5'd11: v = 25'sd917;
            5'd12: v = 25'sd458;
            5'd13: v = 25'sd229;
            5'd14: v = 25'sd115;
            5'd15: v = 25'sd57;
            5'd16: v = 25'sd29;
            5'd17: v = 25'sd14;
            5'd18: v = 25'sd7;
            5'd19: v = 25'sd4;
            5'd20: v = 25'sd2;
            5'd21: v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/pid_go_to_point_drive_control.sv
// ----------------------------------------------------------------------------
// pid_go_to_point_drive_control
// Go-to-point controller: distance and bearing to target, turn and drive PID.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_stall, pose fields  | input
//   out     | o_out_valid, i_out_stall, speeds     | output
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_data      | input
//
// Every item holds the block from acceptance until its result moves to the
// output register. An arrival item skips the 25-step square root; any other
// item runs it (the CORDIC runs beside it) and the two three-term MAC passes
// on the single shared multiplier. Synchronous active-low reset restores
// control, configuration and integrator state. A finished result waits in the
// output register, and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module pid_go_to_point_drive_control #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [15:0]        i_heading_now,
    input  logic               i_first_tick,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic               o_arrived,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);
    import pgtp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQ    = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_ERR   = 7'b0001000,
        ST_TURN  = 7'b0010000,
        ST_DRIVE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    logic signed [23:0] r_tx, r_ty;
    logic [15:0] r_kp_t, r_ki_t, r_kd_t, r_kp_d, r_ki_d, r_kd_d;
    logic signed [31:0] r_bsum;
    logic signed [16:0] r_last_be;
    logic [31:0]        r_dsum;
    logic [24:0]        r_last_d;

    logic signed [24:0] r_dx, r_dy;
    logic [15:0]        r_head;
    logic [2:0]         r_mstep;
    logic signed [16:0] r_e;
    logic signed [17:0] r_brate;
    logic [24:0]        r_d;
    logic signed [25:0] r_drate;
    logic signed [52:0] r_turn;
    logic signed [15:0] r_left, r_right;
    logic               r_arr;
    logic               r_ov;

    t_mac_ctl                  mac_ctl;
    logic signed [ACC_W-1:0]   mac_init, acc;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      aux_start;
    logic [24:0]               root;
    logic                      root_done, crd_done;
    logic signed [16:0]        bearing;

    logic signed [18:0] t0, t1, t2;
    logic signed [32:0] bsum_x;
    logic signed [31:0] n_bsum;
    logic [32:0]        dsum_x;
    logic [31:0]        n_dsum;
    logic signed [51:0] drv_raw;
    logic signed [53:0] drv, lsum, rsum;
    logic signed [15:0] n_left, n_right;
    logic               load_out;

    pgtp_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mac_ctl),
        .i_init (mac_init),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_acc  (acc)
    );

    pgtp_root u_root (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(aux_start),
        .i_sq   (acc[49:0]),
        .o_root (root),
        .o_done (root_done)
    );

    pgtp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (aux_start),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .o_bearing(bearing),
        .o_done   (crd_done)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign aux_start  = (r_state == ST_SQ) && (r_mstep == 3'd3) && (acc[49:0] >= TOL_SQ);
    assign load_out   = (r_state == ST_OUT) && (!r_ov || !i_out_stall);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mac_ctl.issue = 1'b0;
        mac_ctl.clr   = 1'b0;
        mac_init      = '0;
        case (r_state)
            ST_IDLE: begin
                mac_ctl.clr = 1'b1;
            end
            ST_SQ: begin
                mac_ctl.issue = (r_mstep < 3'd2);
                mul_a = (r_mstep == 3'd0) ? MUL_A_W'(r_dx) : MUL_A_W'(r_dy);
                mul_b = (r_mstep == 3'd0) ? MUL_B_W'(r_dx) : MUL_B_W'(r_dy);
            end
            ST_ERR: begin
                mac_ctl.clr = 1'b1;
                mac_init    = ACC_W'(256);
            end
            ST_TURN: begin
                mac_ctl.issue = (r_mstep < 3'd3);
                mac_ctl.clr   = (r_mstep == 3'd4);
                mac_init      = ACC_W'(512);
                case (r_mstep)
                    3'd0: begin
                        mul_a = MUL_A_W'(r_e);
                        mul_b = MUL_B_W'(r_kp_t);
                    end
                    3'd1: begin
                        mul_a = MUL_A_W'(r_bsum);
                        mul_b = MUL_B_W'(r_ki_t);
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_brate);
                        mul_b = MUL_B_W'(r_kd_t);
                    end
                endcase
            end
            ST_DRIVE: begin
                mac_ctl.issue = (r_mstep < 3'd3);
                case (r_mstep)
                    3'd0: begin
                        mul_a = MUL_A_W'({1'b0, r_d});
                        mul_b = MUL_B_W'(r_kp_d);
                    end
                    3'd1: begin
                        mul_a = MUL_A_W'({1'b0, r_dsum});
                        mul_b = MUL_B_W'(r_ki_d);
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_drate);
                        mul_b = MUL_B_W'(r_kd_d);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Bearing error folded into (-180, 180] degrees, and saturating sums.
    always_comb begin
        t0 = 19'(bearing) - 19'({1'b0, r_head});
        t1 = (t0 <= NEG_HALF_TURN) ? t0 + FULL_TURN : t0;
        t2 = (t1 <= NEG_HALF_TURN) ? t1 + FULL_TURN : t1;
        bsum_x = 33'(r_bsum) + 33'(t2);
        if (bsum_x > 33'sh07FFFFFFF) begin
            n_bsum = 32'sh7FFFFFFF;
        end else if (bsum_x < -33'sh080000000) begin
            n_bsum = 32'sh80000000;
        end else begin
            n_bsum = bsum_x[31:0];
        end
        dsum_x = {1'b0, r_dsum} + 33'(root);
        n_dsum = dsum_x[32] ? 32'hFFFFFFFF : dsum_x[31:0];
    end

    always_comb begin
        drv_raw = 52'(acc >>> 10);
        if (drv_raw < DRIVE_MIN) begin
            drv = 54'(DRIVE_MIN);
        end else if (drv_raw > DRIVE_MAX) begin
            drv = 54'(DRIVE_MAX);
        end else begin
            drv = 54'(drv_raw);
        end
        lsum = drv + 54'(r_turn);
        rsum = drv - 54'(r_turn);
        if (lsum > 54'sd32767) begin
            n_left = 16'sh7FFF;
        end else if (lsum < -54'sd32768) begin
            n_left = 16'sh8000;
        end else begin
            n_left = lsum[15:0];
        end
        if (rsum > 54'sd32767) begin
            n_right = 16'sh7FFF;
        end else if (rsum < -54'sd32768) begin
            n_right = 16'sh8000;
        end else begin
            n_right = rsum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx   <= '0;
            r_ty   <= '0;
            r_kp_t <= 16'd128;
            r_ki_t <= '0;
            r_kd_t <= 16'd51;
            r_kp_d <= 16'd512;
            r_ki_d <= '0;
            r_kd_d <= 16'd51;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_X: r_tx   <= i_cfg_data;
                REG_TARGET_Y: r_ty   <= i_cfg_data;
                REG_KP_TURN:  r_kp_t <= i_cfg_data[15:0];
                REG_KI_TURN:  r_ki_t <= i_cfg_data[15:0];
                REG_KD_TURN:  r_kd_t <= i_cfg_data[15:0];
                REG_KP_DRIVE: r_kp_d <= i_cfg_data[15:0];
                REG_KI_DRIVE: r_ki_d <= i_cfg_data[15:0];
                REG_KD_DRIVE: r_kd_d <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mstep   <= '0;
            r_ov      <= 1'b0;
            r_bsum    <= '0;
            r_last_be <= '0;
            r_dsum    <= '0;
            r_last_d  <= '0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_first_tick) begin
                            r_bsum    <= '0;
                            r_last_be <= '0;
                            r_dsum    <= '0;
                            r_last_d  <= '0;
                        end
                        r_mstep <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 3'd3) begin
                        r_state <= aux_start ? ST_CALC : ST_OUT;
                    end
                end
                ST_CALC: begin
                    if (root_done && crd_done) begin
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    r_bsum    <= n_bsum;
                    r_last_be <= t2[16:0];
                    r_dsum    <= n_dsum;
                    r_last_d  <= root;
                    r_mstep   <= '0;
                    r_state   <= ST_TURN;
                end
                ST_TURN: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 3'd4) begin
                        r_mstep <= '0;
                        r_state <= ST_DRIVE;
                    end
                end
                ST_DRIVE: begin
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 3'd4) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Item payload and intermediate results.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_dx   <= 25'(r_tx) - 25'(i_pos_x);
            r_dy   <= 25'(r_ty) - 25'(i_pos_y);
            r_head <= i_heading_now;
        end
        if (r_state == ST_SQ && r_mstep == 3'd3) begin
            r_left  <= '0;
            r_right <= '0;
            r_arr   <= 1'b1;
        end
        if (r_state == ST_ERR) begin
            r_e     <= t2[16:0];
            r_brate <= 18'(t2) - 18'(r_last_be);
            r_d     <= root;
            r_drate <= 26'({1'b0, root}) - 26'({1'b0, r_last_d});
        end
        // Products are registered, then summed; passes are read at step four.
        if (r_state == ST_TURN && r_mstep == 3'd4) begin
            r_turn <= 53'(acc >>> 9);
        end
        if (r_state == ST_DRIVE && r_mstep == 3'd4) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_arr   <= 1'b0;
        end
        if (load_out) begin
            o_left_speed  <= r_left;
            o_right_speed <= r_right;
            o_arrived     <= r_arr;
        end
    end

    assign o_out_valid = r_ov;

endmodule

// File: rtl/pgtp_mac.sv
// ----------------------------------------------------------------------------
// pgtp_mac
// Shared multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module pgtp_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pgtp_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [pgtp_pkg::ACC_W-1:0]    i_init,
    input  logic signed [pgtp_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [pgtp_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [pgtp_pkg::ACC_W-1:0]    o_acc
);
    import pgtp_pkg::*;

    localparam int PROD_W = MUL_A_W + MUL_B_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clr) begin
            r_acc <= i_init;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/pgtp_root.sv
// ----------------------------------------------------------------------------
// pgtp_root
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pgtp_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [49:0] i_sq,
    output logic [24:0] o_root,
    output logic        o_done
);
    import pgtp_pkg::*;

    logic [ROOT_W-1:0] r_rem, r_root, r_bit;
    logic [ROOT_W-1:0] trial;
    logic              r_busy, r_done;

    assign trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= ROOT_W'(i_sq);
            r_root <= '0;
            r_bit  <= ROOT_W'(1) << 48;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_root[24:0];
    assign o_done = r_done;

endmodule

// File: rtl/pgtp_cordic.sv
// ----------------------------------------------------------------------------
// pgtp_cordic
// Vectoring CORDIC for the bearing, one rotation per cycle.
// ----------------------------------------------------------------------------
module pgtp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [24:0] i_dx,
    input  logic signed [24:0] i_dy,
    output logic signed [16:0] o_bearing,
    output logic               o_done
);
    import pgtp_pkg::*;

    logic signed [CRD_W-1:0] r_x, r_y, xs, ys, x0, y0;
    logic signed [ANG_W-1:0] r_z, z0;
    logic [ATAN_IDX_W-1:0]   r_cnt;
    logic                    r_busy, r_done;
    logic signed [ANG_W:0]   zr;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;

    always_comb begin
        x0 = CRD_W'(i_dx) <<< 16;
        y0 = CRD_W'(i_dy) <<< 16;
        z0 = '0;
        // Targets with a negative x offset are folded into the right half plane.
        if (i_dx < 0) begin
            x0 = -x0;
            y0 = -y0;
            z0 = (i_dy >= 0) ? DEG180_FINE : -DEG180_FINE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= x0;
            r_y   <= y0;
            r_z   <= z0;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_fine(r_cnt);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_fine(r_cnt);
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign zr        = (ANG_W+1)'(r_z) + (ANG_W+1)'(128);
    assign o_bearing = 17'(zr >>> 8);
    assign o_done    = r_done;

endmodule

// File: tb/pid_go_to_point_drive_control_tb.sv
// ----------------------------------------------------------------------------
// Go-to-point drive controller testbench
// Drives pose items through the valid/stall input channel and checks every
// wheel-speed result against a cycle-free predictor of distance, bearing,
// turn PID and drive PID. Gains and targets are reprogrammed between phases,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module pid_go_to_point_drive_control_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pgtp_pkg::*;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               arrived;
    } speed_cmd_t;

    localparam longint ARC_TBL [16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
        29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};
    localparam int STALL_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [23:0] i_pos_x;
    logic signed [23:0] i_pos_y;
    logic [15:0]        i_heading_now;
    logic               i_first_tick;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_left_speed;
    logic signed [15:0] o_right_speed;
    logic               o_arrived;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [23:0]        i_cfg_data;

    pid_go_to_point_drive_control i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: configuration and integrators.
    longint     aim_x, aim_y;
    longint     kp_t, ki_t, kd_t, kp_d, ki_d, kd_d;
    longint     err_sum, prev_err, dist_sum, prev_dist;
    speed_cmd_t pending_speeds[$];
    int         fail_count = 0;
    bit         quiet = 1'b0;
    int         stall_cnt = 0;
    int         idle_cycles = 0;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC, angle in 1/32768 degree, rounded to 1/128 degree.
    function automatic longint bearing_to(longint dx, longint dy);
        longint x = dx * 65536;
        longint y = dy * 65536;
        longint z = 0;
        longint xs, ys;
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? 64'sd5898240 : -64'sd5898240;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ARC_TBL[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARC_TBL[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic speed_cmd_t drive_law(logic signed [23:0] px, logic signed [23:0] py,
                                             logic [15:0] hd, logic ft);
        speed_cmd_t c;
        longint dx = aim_x - longint'(px);
        longint dy = aim_y - longint'(py);
        longint sq = dx * dx + dy * dy;
        longint e, rate, turn, d, drv;
        if (ft) begin
            err_sum = 0; prev_err = 0; dist_sum = 0; prev_dist = 0;
        end
        if (sq < 65536) begin
            c.left = 0; c.right = 0; c.arrived = 1'b1;
            return c;
        end
        e = (bearing_to(dx, dy) - longint'(hd)) % 46080;
        if (e < 0) e = e + 46080;
        if (e > 23040) e = e - 46080;
        err_sum = sat(err_sum + e, -64'sd2147483648, 64'sd2147483647);
        rate = e - prev_err;
        prev_err = e;
        turn = (kp_t * e + ki_t * err_sum + kd_t * rate + 256) >>> 9;
        d = int_sqrt(sq);
        dist_sum = sat(dist_sum + d, 0, 64'sd4294967295);
        rate = d - prev_dist;
        prev_dist = d & 64'h1FFFFFF;
        drv = (kp_d * d + ki_d * dist_sum + kd_d * rate + 512) >>> 10;
        drv = sat(drv, 640, 3840);
        c.left = 16'(sat(drv + turn, -32768, 32767));
        c.right = 16'(sat(drv - turn, -32768, 32767));
        c.arrived = 1'b0;
        return c;
    endfunction

    // Receiver stall bursts.
    always @(posedge i_clk) begin
        int nxt;
        nxt = stall_cnt;
        if (nxt > 0) nxt = nxt - 1;
        else if (!quiet && $urandom_range(0, 6) == 0) nxt = $urandom_range(1, 11);
        stall_cnt <= nxt;
        i_out_stall <= (nxt > 0);
    end

    // Result checker and watchdog, sampled mid-cycle where everything is settled.
    always @(negedge i_clk) begin
        speed_cmd_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_speeds.size() == 0) begin
                $error("unexpected result: left %0d right %0d arrived %0d",
                       o_left_speed, o_right_speed, o_arrived);
                fail_count++;
            end else begin
                w = pending_speeds.pop_front();
                if (o_left_speed !== w.left) begin
                    $error("left_speed: expected %0d, got %0d", w.left, o_left_speed);
                    fail_count++;
                end
                if (o_right_speed !== w.right) begin
                    $error("right_speed: expected %0d, got %0d", w.right, o_right_speed);
                    fail_count++;
                end
                if (o_arrived !== w.arrived) begin
                    $error("arrived: expected %0d, got %0d", w.arrived, o_arrived);
                    fail_count++;
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_tick(logic signed [23:0] px, logic signed [23:0] py,
                             logic [15:0] hd, logic ft);
        bit took;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_heading_now <= hd;
        i_first_tick <= ft;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            if (took) pending_speeds.push_back(drive_law(px, py, hd, ft));
            @(posedge i_clk);
        end while (!took);
    endtask

    // Lower valid and wait until every expected result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [23:0] tx, logic [23:0] ty, logic [15:0] g[6]);
        logic [23:0] vals[8];
        vals[0] = tx; vals[1] = ty;
        for (int k = 0; k < 6; k++) vals[k+2] = {8'd0, g[k]};
        drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        aim_x = longint'($signed(tx)); aim_y = longint'($signed(ty));
        kp_t = g[0]; ki_t = g[1]; kd_t = g[2];
        kp_d = g[3]; ki_d = g[4]; kd_d = g[5];
    endtask

    function automatic logic [23:0] near(longint base, int span);
        return 24'(base + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_tick(24'sd0, 24'sd0, 16'd0, 1'b1);           // on target
        send_tick(24'sd255, 24'sd0, 16'd0, 1'b0);         // just inside tolerance
        send_tick(24'sd256, 24'sd0, 16'd0, 1'b0);         // exactly one inch
        send_tick(-24'sd181, -24'sd181, 16'd100, 1'b0);
        send_tick(24'sd1000, 24'sd0, 16'd0, 1'b0);        // target behind on the x axis
        send_tick(24'sd1000, -24'sd3, 16'd46079, 1'b0);
        send_tick(24'sd1000, 24'sd3, 16'hFFFF, 1'b0);     // heading beyond a full turn
        send_tick(24'sd0, 24'sd5000, 16'd23040, 1'b0);
        send_tick(24'sd0, -24'sd5000, 16'd11520, 1'b0);
        send_tick(-24'sd9000, 24'sd7000, 16'd34560, 1'b0);
        send_tick(24'h7FFFFF, 24'h7FFFFF, 16'd0, 1'b0);
        send_tick(24'h800000, 24'h800000, 16'd0, 1'b0);
        send_tick(24'h800000, 24'h7FFFFF, 16'd40000, 1'b1);
    endtask

    task automatic test_extreme_gains();
        logic [15:0] g[6];
        foreach (g[k]) g[k] = 16'hFFFF;
        program_regs(24'h7FFFFF, 24'h800000, g);
        send_tick(24'h800000, 24'h7FFFFF, 16'd0, 1'b1);
        send_tick(24'h800000, 24'h7FFFFF, 16'd23040, 1'b0);
        send_tick(24'h7FFFFF, 24'h7FFF00, 16'd200, 1'b0);
        send_tick(24'h7FFFFF, 24'h800000, 16'd0, 1'b0);
        foreach (g[k]) g[k] = 16'd0;
        program_regs(24'h800000, 24'h7FFFFF, g);
        send_tick(24'h7FFFFF, 24'h800000, 16'd5, 1'b1);
        send_tick(24'h000000, 24'h000000, 16'd46000, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [15:0] g[6];
        logic [23:0] tx, ty, px, py;
        logic [15:0] hd;
        int n;
        for (int ph = 0; ph < 8; ph++) begin
            tx = (ph % 3 == 0) ? 24'($urandom) : near(0, 1 << 16);
            ty = (ph % 3 == 0) ? 24'($urandom) : near(0, 1 << 16);
            foreach (g[k]) g[k] = rand_gain();
            if (ph == 1) g[4] = 16'hFFFF;   // full drive integral gain pushes the drive command to its ceiling
            program_regs(tx, ty, g);
            if (ph == 7) quiet = 1'b1;
            n = 115;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0: begin px = near(aim_x, 300); py = near(aim_y, 300); end
                    1: begin px = 24'($urandom); py = 24'($urandom); end
                    2, 3: begin px = near(aim_x, 1 << 22); py = near(aim_y, 1 << 22); end
                    default: begin px = near(aim_x, 1 << 12); py = near(aim_y, 1 << 12); end
                endcase
                hd = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 46079));
                send_tick(px, py, hd, (k == 0) || ($urandom_range(0, 24) == 0));
                if (ph == 3 && k == 60) drain();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_heading_now <= '0;
        i_first_tick <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_TARGET_X;
        i_cfg_data <= '0;
        aim_x = 0; aim_y = 0;
        kp_t = 128; ki_t = 0; kd_t = 51; kp_d = 512; ki_d = 0; kd_d = 51;
        err_sum = 0; prev_err = 0; dist_sum = 0; prev_dist = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_gains();
        test_random_phases();
        drain();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
